// ===== rtl/core/fsa_pkg.sv =====
// Package for the fraction sum accumulator: widths, word types, sequencer states.
// No dependencies.
package fsa_pkg;

	localparam int TERM_WIDTH = 16;
	localparam int ACC_WIDTH  = 32;
	// cross sum n*b + a*d needs one bit more than the product
	localparam int PROD_WIDTH = ACC_WIDTH + TERM_WIDTH;
	localparam int WIDE_WIDTH = PROD_WIDTH + 1;
	localparam int SH_WIDTH   = $clog2(WIDE_WIDTH + 1);
	localparam int BIT_WIDTH  = $clog2(WIDE_WIDTH);

	typedef struct packed {
		logic [15:0] term_numerator;
		logic [15:0] term_denominator;
		logic        last_term;
	} in_word_t;

	typedef struct packed {
		logic [31:0] sum_numerator;
		logic [31:0] sum_denominator;
		logic        overflow;
	} out_word_t;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_MUL   = 10'b0000000010,
		ST_GZERO = 10'b0000000100,
		ST_GTWO  = 10'b0000001000,
		ST_GAODD = 10'b0000010000,
		ST_GLOOP = 10'b0000100000,
		ST_GSHL  = 10'b0001000000,
		ST_DIVN  = 10'b0010000000,
		ST_DIVD  = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

endpackage

// ===== rtl/core/fsa_divider.sv =====
// Restoring divider, one quotient bit per cycle, over the wide cross-sum width.
// Depends on fsa_pkg.
module fsa_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fsa_pkg::WIDE_WIDTH-1:0] dividend,
	input  logic [fsa_pkg::WIDE_WIDTH-1:0] divisor,
	output logic                          done,
	output logic [fsa_pkg::WIDE_WIDTH-1:0] quotient
);
	import fsa_pkg::*;

	logic [WIDE_WIDTH-1:0] rem_q, quo_q, num_q;
	logic [BIT_WIDTH-1:0]  cnt_q;
	logic                  busy_q, done_q;
	logic [WIDE_WIDTH:0]   trial;

	assign trial    = {rem_q, num_q[WIDE_WIDTH-1]};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= BIT_WIDTH'(WIDE_WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
			num_q <= dividend;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (trial >= {1'b0, divisor}) begin
				rem_q <= WIDE_WIDTH'(trial - {1'b0, divisor});
				quo_q <= {quo_q[WIDE_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= trial[WIDE_WIDTH-1:0];
				quo_q <= {quo_q[WIDE_WIDTH-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== rtl/core/fraction_sum_accumulator.sv =====
// Fraction sum accumulator top level: sequencer, multiplier, binary gcd, divider.
// Depends on fsa_pkg and fsa_divider.
//
// Adds a sequence of unsigned fractions exactly and keeps the sum reduced by
// its gcd; the word with last_term set returns one result and clears the sum.
// One word is handled at a time and in is not ready meanwhile. The first word
// of a sequence is stored as the sum directly. A later word goes through the
// multiply steps, then a binary gcd by shifts and subtractions of the 49-bit
// cross sum (skipped for a zero numerator), then two divisions by the gcd,
// of the numerator and of the denominator, then a store. The divider gives
// one quotient bit per cycle. A result waits in an output register until taken.
module fraction_sum_accumulator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fsa_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output fsa_pkg::out_word_t out_data
);
	import fsa_pkg::*;

	state_t state_q;
	logic [ACC_WIDTH-1:0]  acc_n_q, acc_d_q;
	logic                  first_q, ovf_q, last_q;
	logic [TERM_WIDTH-1:0] tn_q, td_q;
	logic [WIDE_WIDTH-1:0] n_q, d_q, ga_q, gb_q, g_q, qn_q;
	logic [SH_WIDTH-1:0]   k_q;
	logic [1:0]            mstep_q;
	logic [PROD_WIDTH-1:0] prod;
	logic [ACC_WIDTH-1:0]  mul_a;
	logic [TERM_WIDTH-1:0] mul_b;
	logic                  out_valid_q;
	out_word_t             out_q;
	logic                  div_start, div_done;
	logic [WIDE_WIDTH-1:0] div_num, div_q;
	logic [TERM_WIDTH-1:0] in_tn, in_td;

	assign in_tn = in_data.term_numerator[TERM_WIDTH-1:0];
	assign in_td = (in_data.term_denominator[TERM_WIDTH-1:0] == '0) ? TERM_WIDTH'(1)
		: in_data.term_denominator[TERM_WIDTH-1:0];

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// one shared multiplier: acc_n*b, then a*acc_d, then acc_d*b
	always_comb begin
		case (mstep_q)
			2'd0:    begin mul_a = acc_n_q; mul_b = td_q; end
			2'd1:    begin mul_a = acc_d_q; mul_b = tn_q; end
			default: begin mul_a = acc_d_q; mul_b = td_q; end
		endcase
	end
	assign prod = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);

	assign div_num = (state_q == ST_DIVN) ? n_q : d_q;

	fsa_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (g_q),
		.done     (div_done),
		.quotient (div_q)
	);

	logic div_go_q;
	assign div_start = div_go_q;

	function automatic logic fits(input logic [WIDE_WIDTH-1:0] v);
		return (v >> ACC_WIDTH) == '0;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_n_q     <= '0;
			acc_d_q     <= ACC_WIDTH'(1);
			first_q     <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			div_go_q    <= 1'b0;
			mstep_q     <= '0;
			last_q      <= 1'b0;
			tn_q        <= '0;
			td_q        <= '0;
			n_q         <= '0;
			d_q         <= '0;
			ga_q        <= '0;
			gb_q        <= '0;
			g_q         <= '0;
			qn_q        <= '0;
			k_q         <= '0;
			out_q       <= '0;
		end else begin
			div_go_q <= 1'b0;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						last_q <= in_data.last_term;
						tn_q   <= in_tn;
						td_q   <= in_td;
						if (!first_q) begin
							acc_n_q <= ACC_WIDTH'(in_tn);
							acc_d_q <= ACC_WIDTH'(in_td);
							first_q <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							mstep_q <= '0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					mstep_q <= mstep_q + 1'b1;
					case (mstep_q)
						2'd0:    n_q <= WIDE_WIDTH'(prod);
						2'd1:    n_q <= n_q + WIDE_WIDTH'(prod);
						default: begin
							d_q     <= WIDE_WIDTH'(prod);
							state_q <= ST_GZERO;
						end
					endcase
				end
				ST_GZERO: begin
					ga_q <= n_q;
					gb_q <= d_q;
					k_q  <= '0;
					// zero numerator: gcd is d, so the sum reduces to 0/1
					if (n_q == '0) begin
						g_q      <= d_q;
						div_go_q <= 1'b1;
						state_q  <= ST_DIVN;
					end else begin
						state_q <= ST_GTWO;
					end
				end
				ST_GTWO: begin
					if (ga_q[0] | gb_q[0]) state_q <= ST_GAODD;
					else begin
						ga_q <= ga_q >> 1;
						gb_q <= gb_q >> 1;
						k_q  <= k_q + 1'b1;
					end
				end
				ST_GAODD: begin
					if (ga_q[0]) state_q <= ST_GLOOP;
					else ga_q <= ga_q >> 1;
				end
				ST_GLOOP: begin
					if (gb_q == '0) begin
						g_q     <= ga_q;
						state_q <= ST_GSHL;
					end else if (!gb_q[0]) begin
						gb_q <= gb_q >> 1;
					end else if (gb_q >= ga_q) begin
						gb_q <= gb_q - ga_q;
					end else begin
						ga_q <= gb_q;
						gb_q <= ga_q - gb_q;
					end
				end
				ST_GSHL: begin
					if (k_q == '0) begin
						div_go_q <= 1'b1;
						state_q  <= ST_DIVN;
					end else begin
						g_q <= g_q << 1;
						k_q <= k_q - 1'b1;
					end
				end
				ST_DIVN: begin
					if (div_done) begin
						qn_q     <= div_q;
						div_go_q <= 1'b1;
						state_q  <= ST_DIVD;
					end
				end
				ST_DIVD: begin
					if (div_done) begin
						if (!fits(qn_q) || !fits(div_q)) ovf_q <= 1'b1;
						acc_n_q <= qn_q[ACC_WIDTH-1:0];
						acc_d_q <= (div_q[ACC_WIDTH-1:0] == '0) ? ACC_WIDTH'(1)
							: div_q[ACC_WIDTH-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q.sum_numerator   <= 32'(acc_n_q);
						out_q.sum_denominator <= 32'(acc_d_q);
						out_q.overflow        <= ovf_q;
						acc_n_q <= '0;
						acc_d_q <= ACC_WIDTH'(1);
						first_q <= 1'b0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/fsa_checker.sv =====
// Port-level checks for the fraction sum accumulator, bound to the top level.
// Depends on fsa_pkg and fraction_sum_accumulator.
module fsa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input fsa_pkg::in_word_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input fsa_pkg::out_word_t out_data
);
	import fsa_pkg::*;

	// a word is never taken in the cycle right after another one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("back to back accept");

	// a result only follows an accepted word
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready)) else $error("result without work");

	// a reduced denominator is never zero
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.sum_denominator != '0) else $error("zero denominator");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

endmodule

bind fraction_sum_accumulator fsa_checker u_fsa_checker (.*);

// ===== tb/tb_top.sv =====
// Testbench for fraction_sum_accumulator: random fraction sequences, sums checked
// against an in-bench exact rational predictor. Depends on fsa_pkg and the RTL.
module tb_top;
	import fsa_pkg::*;

	class sum_scoreboard;
		logic [ACC_WIDTH-1:0] acc_num;
		logic [ACC_WIDTH-1:0] acc_den;
		bit have_first;
		bit ovf;
		out_word_t sums_due[$];
		int errors;

		function new();
			clear();
			errors = 0;
		endfunction

		function void clear();
			acc_num = '0;
			acc_den = 1;
			have_first = 0;
			ovf = 0;
		endfunction

		function logic [127:0] gcd128(logic [127:0] a, logic [127:0] b);
			logic [127:0] t;
			if (a == 0) begin
				return b;
			end
			while (b != 0) begin
				t = a % b;
				a = b;
				b = t;
			end
			return a;
		endfunction

		function void keep(logic [127:0] n, logic [127:0] d);
			if ((n >> ACC_WIDTH) != 0 || (d >> ACC_WIDTH) != 0) begin
				ovf = 1;
			end
			acc_num = n[ACC_WIDTH-1:0];
			acc_den = d[ACC_WIDTH-1:0];
			if (acc_den == 0) begin
				acc_den = 1;
			end
		endfunction

		function void note_term(in_word_t w);
			logic [127:0] tn;
			logic [127:0] td;
			logic [127:0] n;
			logic [127:0] d;
			logic [127:0] g;
			out_word_t r;
			tn = w.term_numerator;
			td = w.term_denominator;
			if (td == 0) begin
				td = 1;
			end
			if (!have_first) begin
				keep(tn, td);
				have_first = 1;
			end else begin
				n = acc_num * td + tn * acc_den;
				d = acc_den * td;
				g = gcd128(n, d);
				keep(n / g, d / g);
			end
			if (w.last_term) begin
				r.sum_numerator = acc_num;
				r.sum_denominator = acc_den;
				r.overflow = ovf;
				sums_due.push_back(r);
				clear();
			end
		endfunction

		function void check_sum(out_word_t got);
			out_word_t exp;
			if (sums_due.size() == 0) begin
				$display("%0t: unexpected sum, got %h", $time, got);
				errors++;
				return;
			end
			exp = sums_due.pop_front();
			if (got.sum_numerator !== exp.sum_numerator) begin
				$display("%0t: numerator exp %0d got %0d", $time,
					exp.sum_numerator, got.sum_numerator);
				errors++;
			end
			if (got.sum_denominator !== exp.sum_denominator) begin
				$display("%0t: denominator exp %0d got %0d", $time,
					exp.sum_denominator, got.sum_denominator);
				errors++;
			end
			if (got.overflow !== exp.overflow) begin
				$display("%0t: overflow exp %0b got %0b", $time,
					exp.overflow, got.overflow);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_word_t out_data;

	sum_scoreboard sb = new();
	bit quiet = 0;
	bit hold_sink = 0;
	longint cycles = 0;

	always #5 clk = ~clk;

	fraction_sum_accumulator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			sb.note_term(in_data);
		end
		if (arst_n && out_valid && out_ready) begin
			sb.check_sum(out_data);
		end
	end

	// sink: random stall bursts, or a long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				out_ready <= 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 0;
				n = $urandom_range(1, 6);
				repeat (n) @(posedge clk);
				out_ready <= 1;
			end else begin
				out_ready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// valid stays up from one word to the next unless the source idles
	task automatic send_term(logic [15:0] num, logic [15:0] den, logic last);
		int n;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			n = $urandom_range(1, 6);
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{term_numerator: num, term_denominator: den, last_term: last};
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [15:0] rnd_field();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 15));
			1: return 16'hFFFF - 16'($urandom_range(0, 15));
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic wait_drained();
		in_valid <= 0;
		while (sb.sums_due.size() != 0) @(posedge clk);
	endtask

	initial begin
		int len;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, zero denominator, zero sum, single-term sequence, overflow
		send_term(16'hFFFF, 16'hFFFF, 1);
		send_term(0, 5, 1);
		send_term(0, 0, 0);
		send_term(0, 7, 1);
		send_term(1, 2, 0);
		send_term(1, 3, 0);
		send_term(1, 6, 1);
		send_term(16'hFFFF, 1, 0);
		send_term(16'hFFFF, 1, 1);
		send_term(1, 16'hFFFF, 0);
		send_term(1, 16'hFFFE, 0);
		send_term(1, 16'hFFFD, 1);
		send_term(16'h8000, 0, 0);
		send_term(16'h7FFF, 16'h8000, 1);
		wait_drained();

		// long sink hold-off while the source keeps offering words
		hold_sink = 1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_sink = 0;
			end
			repeat (6) send_term(16'($urandom()), 16'($urandom()), 1'b1);
		join
		wait_drained();

		for (int i = 0; i < 480; ) begin
			if (i > 400) begin
				quiet = 1;
			end
			len = $urandom_range(1, 5);
			for (int k = 0; k < len; k++) begin
				send_term(rnd_field(), rnd_field(), k == len - 1);
			end
			i += len;
		end
		wait_drained();
		repeat (400) @(posedge clk);
		if (sb.errors == 0 && sb.sums_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/fsa_pkg.sv
rtl/core/fsa_divider.sv
rtl/core/fraction_sum_accumulator.sv
rtl/core/fsa_checker.sv
tb/tb_top.sv
